@@ rtl/ffba_pkg.sv @@
// shared types and constants of the first-fit block allocator
package ffba_pkg;

    // field widths fixed by the interface
    localparam int LEN_W    = 7;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

    // one entry of the block table
    typedef struct packed {
        logic             used;
        logic             head;
        logic [LEN_W-1:0] len;
    } t_blk_word;

    // sequencer states
    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_FCHK  = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // control of the run tracking unit
    typedef struct packed {
        logic clear;
        logic step;
        logic used;
    } t_run_ctl;

endpackage

@@ rtl/first_fit_block_allocator.sv @@
// first-fit contiguous block allocator, top level with sequencer
// All block state (used bit, head flag, run length) lives in one single-port
// table of NUM_BLOCKS words, and that one port paces every item. After reset
// a clearing pass writes every entry, during which no word is accepted. An
// allocate is accepted, then reads the table block by block from block 0 up
// to the end of the first fitting run, writes alloc_count entries to mark the
// run, and finishes and posts the result. An allocate with a count of zero or
// beyond the pool goes straight to posting its result. A free is accepted
// while its head entry is read, checks the head, clears one entry per block
// of the run, and finishes and posts the result; a rejected free posts its
// result right after the head check. Posting waits while a stalled result
// still sits in the output register. One word is in work at a time; the
// result register lets the next word in while a result waits.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [6:0]                    i_alloc_count,
    input  logic [5:0]                    i_free_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ffba_pkg::STATUS_W-1:0] o_status,
    output logic [ffba_pkg::IDX_W-1:0]    o_start_index
);
    import ffba_pkg::*;

    localparam int POS_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_BLOCKS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_BLOCKS - 1);

    // control registers
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic              r_eval_vld, n_eval_vld;
    logic              r_out_vld, n_out_vld;

    // payload registers
    logic [LEN_W-1:0]    r_left, n_left;
    logic                r_first, n_first;
    logic                r_op, n_op;
    logic [LEN_W-1:0]    r_want, n_want;
    logic [POS_W-1:0]    r_eval_pos, n_eval_pos;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [IDX_W-1:0]    r_res_start, n_res_start;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [IDX_W-1:0]    r_out_start, n_out_start;

    // table port
    logic             ram_we;
    logic [POS_W-1:0] ram_addr;
    t_blk_word        ram_wdata;
    t_blk_word        ram_rdata;

    // run tracking unit
    t_run_ctl         run_ctl;
    logic             run_hit;
    logic [POS_W-1:0] run_start;

    logic in_accept;
    logic out_take;
    logic count_ok;
    logic idx_ok;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_vld && !i_out_stall;
    assign count_ok  = (i_alloc_count != '0) && (32'(i_alloc_count) <= NUM_BLOCKS);
    assign idx_ok    = 32'(i_free_index) < NUM_BLOCKS;

    ffba_ram #(
        .WIDTH($bits(t_blk_word)),
        .DEPTH(NUM_BLOCKS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    ffba_run_unit #(
        .POS_W(POS_W)
    ) u_run (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (run_ctl),
        .i_pos  (r_eval_pos),
        .i_want (r_want),
        .o_hit  (run_hit),
        .o_start(run_start)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_eval_vld   = 1'b0;
        n_eval_pos   = r_eval_pos;
        n_left       = r_left;
        n_first      = r_first;
        n_op         = r_op;
        n_want       = r_want;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_out_vld    = out_take ? 1'b0 : r_out_vld;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;

        ram_we          = 1'b0;
        ram_addr        = r_wr_ptr[POS_W-1:0];
        ram_wdata       = '0;
        run_ctl.clear   = in_accept;
        run_ctl.step    = (r_state == S_SCAN) && r_eval_vld;
        run_ctl.used    = ram_rdata.used;

        case (r_state)
            // clear the whole table after reset
            S_INIT: begin
                ram_we   = 1'b1;
                n_wr_ptr = CNT_W'(r_wr_ptr + 1'b1);
                if (r_wr_ptr[POS_W-1:0] == POS_LAST) begin
                    n_state = S_IDLE;
                end
            end
            // take a word, read the head entry for a free
            S_IDLE: begin
                ram_addr = POS_W'(i_free_index);
                if (in_accept) begin
                    n_op         = i_op;
                    n_want       = i_alloc_count;
                    n_res_start  = '0;
                    n_res_status = ST_OK;
                    n_rd_ptr     = '0;
                    n_wr_ptr     = CNT_W'(i_free_index);
                    if (i_op == OP_ALLOC) begin
                        if (count_ok) begin
                            n_state = S_SCAN;
                        end else begin
                            n_res_status = ST_NOFIT;
                            n_state      = S_DONE;
                        end
                    end else begin
                        if (idx_ok) begin
                            n_state = S_FCHK;
                        end else begin
                            n_res_status = ST_BADFREE;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            // pipelined bitmap scan, one read issued and one block judged per cycle
            S_SCAN: begin
                ram_addr = r_rd_ptr[POS_W-1:0];
                if (r_rd_ptr < CNT_END) begin
                    n_rd_ptr   = CNT_W'(r_rd_ptr + 1'b1);
                    n_eval_vld = 1'b1;
                    n_eval_pos = r_rd_ptr[POS_W-1:0];
                end
                if (r_eval_vld) begin
                    if (run_hit) begin
                        n_state     = S_WRITE;
                        n_wr_ptr    = CNT_W'(run_start);
                        n_left      = r_want;
                        n_first     = 1'b1;
                        n_res_start = IDX_W'(run_start);
                    end else if (r_eval_pos == POS_LAST) begin
                        n_res_status = ST_NOFIT;
                        n_state      = S_DONE;
                    end
                end
            end
            // head check for a free
            S_FCHK: begin
                if (ram_rdata.used && ram_rdata.head) begin
                    n_left  = ram_rdata.len;
                    n_first = 1'b1;
                    n_state = S_WRITE;
                end else begin
                    n_res_status = ST_BADFREE;
                    n_state      = S_DONE;
                end
            end
            // mark or clear the run, one block per cycle, bounded at pool end
            S_WRITE: begin
                if ((r_left != '0) && (r_wr_ptr < CNT_END)) begin
                    ram_we         = 1'b1;
                    ram_wdata.used = (r_op == OP_ALLOC);
                    ram_wdata.head = (r_op == OP_ALLOC) && r_first;
                    ram_wdata.len  = ((r_op == OP_ALLOC) && r_first) ? r_want : '0;
                    n_wr_ptr       = CNT_W'(r_wr_ptr + 1'b1);
                    n_left         = LEN_W'(r_left - 1'b1);
                    n_first        = 1'b0;
                end else begin
                    n_state = S_DONE;
                end
            end
            // post the result once the output register is free
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_start  = r_res_start;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_eval_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_eval_vld <= n_eval_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_first      <= n_first;
        r_op         <= n_op;
        r_want       <= n_want;
        r_eval_pos   <= n_eval_pos;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_start_index = r_out_start;

endmodule

@@ rtl/ffba_ram.sv @@
// generic single-port ram with registered read
module ffba_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read-first
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ffba_run_unit.sv @@
// free run tracker: counts consecutive free blocks and compares against the request
module ffba_run_unit #(
    parameter int POS_W = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ffba_pkg::t_run_ctl       i_ctl,
    input  logic [POS_W-1:0]         i_pos,
    input  logic [ffba_pkg::LEN_W-1:0] i_want,
    output logic                     o_hit,
    output logic [POS_W-1:0]         o_start
);
    import ffba_pkg::*;

    logic [LEN_W-1:0] r_run_len;
    logic [LEN_W-1:0] n_run_len;
    logic [POS_W-1:0] r_run_start;
    logic [POS_W-1:0] n_run_start;
    logic [LEN_W-1:0] len_inc;

    // run start is the current block when a new run opens
    always_comb begin
        len_inc     = LEN_W'(r_run_len + 1'b1);
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        o_start     = (r_run_len == '0) ? i_pos : r_run_start;
        o_hit       = i_ctl.step && !i_ctl.used && (len_inc >= i_want);
        if (i_ctl.clear) begin
            n_run_len = '0;
        end else if (i_ctl.step) begin
            if (i_ctl.used) begin
                n_run_len = '0;
            end else begin
                n_run_len   = len_inc;
                n_run_start = o_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len <= '0;
        end else begin
            r_run_len <= n_run_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_start <= n_run_start;
    end

endmodule

@@ rtl/ffba_checker.sv @@
// port-level checks of the first-fit block allocator and their bind
module ffba_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [ffba_pkg::STATUS_W-1:0] o_status,
    input logic [ffba_pkg::IDX_W-1:0]    o_start_index
);
    import ffba_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_start_index)))
        else $error("stalled result word changed");

    // a failed request carries a zero start index
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_start_index == '0))
        else $error("start index not zero on error status");

    // an accepted word makes the block busy in the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting a word");

    // a new result appears only at the end of work on a word
    a_post_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result posted while idle");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

@@ tb/first_fit_block_allocator_tb.sv @@
// self-checking testbench of the first-fit block allocator with a scoreboard class
module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    localparam int NUM_BLOCKS  = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int WORDS_PHASE = 650;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_op;
    logic [LEN_W-1:0]    i_alloc_count;
    logic [IDX_W-1:0]    i_free_index;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_start_index;

    int send_idle_pct;
    int recv_idle_pct;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    start;
    } t_reply;

    // block table mirror, expected replies and outcome counters
    class alloc_scoreboard;
        logic             used_q [NUM_BLOCKS];
        logic             head_q [NUM_BLOCKS];
        logic [LEN_W-1:0] len_q  [NUM_BLOCKS];
        t_reply           expected_replies[$];
        int               errors;
        int               words_in;
        int               grants;
        int               no_fits;
        int               releases;
        int               bad_frees;

        function new();
            foreach (used_q[i]) begin
                used_q[i] = 1'b0;
                head_q[i] = 1'b0;
                len_q[i]  = '0;
            end
            errors    = 0;
            words_in  = 0;
            grants    = 0;
            no_fits   = 0;
            releases  = 0;
            bad_frees = 0;
        endfunction

        // first-fit search and table update for one request word
        function t_reply predict_reply(logic op, logic [LEN_W-1:0] cnt,
                                       logic [IDX_W-1:0] idx);
            t_reply r;
            int     run_start;
            int     run_len;
            int     at;
            r.status  = ST_OK;
            r.start   = '0;
            at        = -1;
            run_start = 0;
            run_len   = 0;
            if (op == OP_ALLOC) begin
                if (cnt != 0 && cnt <= NUM_BLOCKS) begin
                    for (int pos = 0; pos < NUM_BLOCKS && at < 0; pos++) begin
                        if (used_q[pos]) begin
                            run_len = 0;
                        end else begin
                            if (run_len == 0) run_start = pos;
                            run_len++;
                            if (run_len >= cnt) at = run_start;
                        end
                    end
                end
                if (at >= 0) begin
                    for (int k = 0; k < cnt; k++) used_q[at + k] = 1'b1;
                    head_q[at] = 1'b1;
                    len_q[at]  = cnt;
                    r.start    = at[IDX_W-1:0];
                    grants++;
                end else begin
                    r.status = ST_NOFIT;
                    no_fits++;
                end
            end else begin
                if (head_q[idx] && used_q[idx]) begin
                    for (int k = 0; k < len_q[idx] && idx + k < NUM_BLOCKS; k++)
                        used_q[idx + k] = 1'b0;
                    head_q[idx] = 1'b0;
                    len_q[idx]  = '0;
                    releases++;
                end else begin
                    r.status = ST_BADFREE;
                    bad_frees++;
                end
            end
            return r;
        endfunction

        function void note_request(logic op, logic [LEN_W-1:0] cnt, logic [IDX_W-1:0] idx);
            expected_replies.push_back(predict_reply(op, cnt, idx));
            words_in++;
        endfunction

        function void check_reply(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] start);
            t_reply e;
            if (expected_replies.size() == 0) begin
                $error("reply word with none expected: status %0d start_index %0d",
                       status, start);
                errors++;
                return;
            end
            e = expected_replies.pop_front();
            if (status !== e.status) begin
                $error("status mismatch: expected %0d, actual %0d", e.status, status);
                errors++;
            end
            if (start !== e.start) begin
                $error("start_index mismatch: expected %0d, actual %0d", e.start, start);
                errors++;
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        // a random live run head, or -1 when the pool holds none
        function int pick_head();
            int heads[$];
            for (int i = 0; i < NUM_BLOCKS; i++)
                if (head_q[i] && used_q[i]) heads.push_back(i);
            if (heads.size() == 0) return -1;
            return heads[$urandom_range(heads.size() - 1)];
        endfunction
    endclass

    alloc_scoreboard sb;

    first_fit_block_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_alloc_count(i_alloc_count),
        .i_free_index (i_free_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_start_index(o_start_index)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // present one request word and hold it until accepted
    task automatic send_word(logic op, logic [LEN_W-1:0] cnt, logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_alloc_count <= cnt;
        i_free_index  <= idx;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(op, cnt, idx);
    endtask

    // unused field of each request carries random content
    task automatic send_alloc(logic [LEN_W-1:0] cnt);
        send_word(OP_ALLOC, cnt, IDX_W'($urandom));
    endtask

    task automatic send_free(logic [IDX_W-1:0] idx);
        send_word(OP_FREE, LEN_W'($urandom), idx);
    endtask

    // hold off the sender until every expected reply has come back
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // extremes, full pool, holes and the scan bound at the pool end
    task automatic run_directed();
        send_alloc(0);
        send_alloc(64);
        send_alloc(1);
        send_free(1);
        send_free(0);
        send_free(0);
        send_alloc(65);
        send_alloc(127);
        send_alloc(1);
        send_alloc(2);
        send_alloc(61);
        send_alloc(1);
        send_free(1);
        send_alloc(3);
        send_alloc(2);
        send_free(63);
        send_free(3);
        send_alloc(62);
        send_alloc(61);
        send_free(0);
        send_free(1);
        send_free(3);
        send_free(32);
    endtask

    // mostly small allocates and frees of live heads, some noise
    task automatic random_word();
        int               pick;
        int               head;
        logic [LEN_W-1:0] cnt;
        pick = $urandom_range(99);
        if (pick < 55) begin
            pick = $urandom_range(99);
            if (pick < 70)      cnt = LEN_W'($urandom_range(1, 8));
            else if (pick < 92) cnt = LEN_W'($urandom_range(9, 64));
            else if (pick < 96) cnt = '0;
            else                cnt = LEN_W'($urandom_range(65, 127));
            send_alloc(cnt);
        end else begin
            head = sb.pick_head();
            if (head >= 0 && $urandom_range(99) < 85) send_free(IDX_W'(head));
            else                                      send_free(IDX_W'($urandom));
        end
    endtask

    // reply side: check accepted words, stall at random
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
                sb.check_reply(o_status, o_start_index);
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d quiet cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // stimulus sequence and verdict
    initial begin : main_seq
        sb = new();
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_op          <= OP_ALLOC;
        i_alloc_count <= '0;
        i_free_index  <= '0;
        send_idle_pct = 13;
        recv_idle_pct = 64;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_replies();

        // three idle mixes: slow receiver, slow sender, none
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < WORDS_PHASE; n++) random_word();
            drain_replies();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d request words: %0d runs granted, %0d refused for no fit",
                 sb.words_in, sb.grants, sb.no_fits);
        $display("frees: %0d runs released, %0d rejected as not a used head",
                 sb.releases, sb.bad_frees);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/ffba_run_unit.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_checker.sv
tb/first_fit_block_allocator_tb.sv
